[hw/rtl/imu_sfp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// imu_sfp_pkg
// Shared types and constants for the IMU serial frame parser.
// ----------------------------------------------------------------------------
package imu_sfp_pkg;

    localparam int          DEF_KEPT_BYTES = 6;
    localparam int          OUT_DATA       = 6;
    localparam int          POS_W          = 4;
    localparam int          KIND_COUNT     = 3;
    localparam int          FIRST_DATA_POS = 2;

    localparam logic [7:0]  HDR_BYTE       = 8'h55;
    localparam logic [7:0]  KIND_BASE      = 8'h51;
    localparam logic [7:0]  KIND_LAST      = 8'h53;

    localparam logic [3:0]  POS_HDR        = 4'd0;
    localparam logic [3:0]  POS_KIND       = 4'd1;
    localparam logic [3:0]  POS_CHECK      = 4'd10;

    typedef logic [7:0]  t_byte;
    typedef logic [1:0]  t_kind;
    typedef logic [15:0] t_count;

    typedef struct packed {
        t_kind                        kind;
        logic [OUT_DATA-1:0][7:0]     data;
        t_count                       count;
    } t_frame;

endpackage

`default_nettype wire

[hw/rtl/imu_sfp_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// imu_sfp_if
// Valid/ready channels for received bytes and parsed frames.
// ----------------------------------------------------------------------------
interface imu_sfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface imu_sfp_frame_if;
    logic        valid;
    logic        ready;
    logic [1:0]  frame_kind;
    logic [7:0]  data_byte0;
    logic [7:0]  data_byte1;
    logic [7:0]  data_byte2;
    logic [7:0]  data_byte3;
    logic [7:0]  data_byte4;
    logic [7:0]  data_byte5;
    logic [15:0] frames_received;

    modport source (
        output valid, output frame_kind,
        output data_byte0, output data_byte1, output data_byte2,
        output data_byte3, output data_byte4, output data_byte5,
        output frames_received, input ready
    );
    modport sink (
        input valid, input frame_kind,
        input data_byte0, input data_byte1, input data_byte2,
        input data_byte3, input data_byte4, input data_byte5,
        input frames_received, output ready
    );
endinterface

`default_nettype wire

[hw/rtl/imu_sfp_step.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// imu_sfp_step
// Frame state, payload store and per-kind counters; one byte per transfer.
// ----------------------------------------------------------------------------
module imu_sfp_step
    import imu_sfp_pkg::*;
#(
    parameter int KEPT_BYTES = DEF_KEPT_BYTES
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_fire,
    input  wire t_byte  i_byte,
    output logic        o_emit,
    output t_frame      o_frame
);

    logic [POS_W-1:0]  r_pos, n_pos;
    t_byte             r_sum, n_sum;
    t_kind             r_kind, n_kind;
    t_count            r_cnt [KIND_COUNT];
    t_byte             r_store [KEPT_BYTES];

    t_byte             sum_add;
    t_kind             kind_diff;
    logic              kind_ok;
    t_kind             cur_k;
    t_count            cnt_inc;

    assign sum_add   = r_sum + i_byte;
    assign kind_diff = t_kind'(i_byte - KIND_BASE);
    assign kind_ok   = (i_byte >= KIND_BASE) && (i_byte <= KIND_LAST);
    assign cur_k     = (r_kind >= t_kind'(KIND_COUNT)) ? '0 : r_kind;
    assign cnt_inc   = r_cnt[cur_k] + 16'd1;

    always_comb begin
        n_pos  = r_pos;
        n_sum  = r_sum;
        n_kind = r_kind;
        o_emit = 1'b0;
        if (i_fire) begin
            priority if (r_pos >= POS_CHECK) begin
                o_emit = (r_sum == i_byte);
                n_pos  = '0;
                n_sum  = '0;
                n_kind = '0;
            end else if (r_pos == POS_HDR) begin
                if (i_byte == HDR_BYTE) begin
                    n_pos = POS_KIND;
                    n_sum = sum_add;
                end
            end else if (r_pos == POS_KIND) begin
                if (kind_ok) begin
                    n_kind = kind_diff;
                    n_sum  = sum_add;
                    n_pos  = r_pos + 4'd1;
                end else begin
                    n_pos = '0;
                    n_sum = '0;
                end
            end else begin
                n_sum = sum_add;
                n_pos = r_pos + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_sum  <= '0;
            r_kind <= '0;
            for (int k = 0; k < KIND_COUNT; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            r_pos  <= n_pos;
            r_sum  <= n_sum;
            r_kind <= n_kind;
            if (o_emit) begin
                r_cnt[cur_k] <= cnt_inc;
            end
        end
    end

    for (genvar e = 0; e < KEPT_BYTES; e++) begin : g_store
        localparam logic [POS_W-1:0] WR_POS = POS_W'(FIRST_DATA_POS + e);
        always_ff @(posedge i_clk) begin
            if (i_fire && (r_pos == WR_POS)) begin
                r_store[e] <= i_byte;
            end
        end
    end

    assign o_frame.kind  = cur_k;
    assign o_frame.count = cnt_inc;

    for (genvar j = 0; j < OUT_DATA; j++) begin : g_out
        if (j < KEPT_BYTES) begin : g_kept
            assign o_frame.data[j] = r_store[j];
        end else begin : g_zero
            assign o_frame.data[j] = '0;
        end
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_CHECK)
        else $error("frame position out of range");

    a_emit_at_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |-> (i_fire && r_pos >= POS_CHECK))
        else $error("result outside checksum position");

    a_check_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && r_pos >= POS_CHECK) |=> (r_pos == POS_HDR && r_sum == '0))
        else $error("state not cleared after checksum");

    a_bad_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && r_pos == POS_KIND && !kind_ok) |=> (r_pos == POS_HDR && r_sum == '0))
        else $error("bad kind byte did not abandon frame");

    a_hdr_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && r_pos == POS_HDR && i_byte != HDR_BYTE) |=> (r_pos == POS_HDR))
        else $error("wrong header byte not skipped");

endmodule

`default_nettype wire

[hw/rtl/imu_serial_frame_parser_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// imu_serial_frame_parser_core
// Parses 11-byte IMU sensor frames from a byte stream.
// ----------------------------------------------------------------------------
// Each byte is first held in the input register, then parsed by the step
// once the result register has room; a result is offered from the result
// register. Throughput: one byte per cycle while the result is not stalled.
// Reset clears position, sum, kind, per-kind counters and both valid flags;
// the payload store is not cleared.
// ----------------------------------------------------------------------------
module imu_serial_frame_parser_core
    import imu_sfp_pkg::*;
#(
    parameter int KEPT_BYTES = DEF_KEPT_BYTES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    imu_sfp_byte_if.sink     i_byte,
    imu_sfp_frame_if.source  o_frame
);

    logic    r_in_valid;
    t_byte   r_in_byte;
    logic    r_out_valid;
    t_frame  r_out_frame;

    logic    proc;
    logic    emit;
    t_frame  step_frame;

    assign proc         = r_in_valid && (!r_out_valid || o_frame.ready);
    assign i_byte.ready = !r_in_valid || proc;

    imu_sfp_step #(
        .KEPT_BYTES (KEPT_BYTES)
    ) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (proc),
        .i_byte  (r_in_byte),
        .o_emit  (emit),
        .o_frame (step_frame)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_byte.valid && i_byte.ready) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (proc) begin
                r_out_valid <= emit;
            end else if (o_frame.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.rx_byte;
        end
        if (proc && emit) begin
            r_out_frame <= step_frame;
        end
    end

    assign o_frame.valid           = r_out_valid;
    assign o_frame.frame_kind      = r_out_frame.kind;
    assign o_frame.data_byte0      = r_out_frame.data[0];
    assign o_frame.data_byte1      = r_out_frame.data[1];
    assign o_frame.data_byte2      = r_out_frame.data[2];
    assign o_frame.data_byte3      = r_out_frame.data[3];
    assign o_frame.data_byte4      = r_out_frame.data[4];
    assign o_frame.data_byte5      = r_out_frame.data[5];
    assign o_frame.frames_received = r_out_frame.count;

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_frame.ready) |=> (r_out_valid && $stable(r_out_frame)))
        else $error("pending result lost while stalled");

    a_step_only_with_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc |-> (r_in_valid && (!r_out_valid || o_frame.ready)))
        else $error("byte parsed without room for its result");

    a_result_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(proc && emit))
        else $error("result raised without a parsed checksum");

endmodule

`default_nettype wire
